[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error("scheduler check failed");

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
		else $error("scheduler check failed");

`endif

[hw/rtl/rrts_pkg.sv]
// ----------------------------------------------------------------------------
// rrts_pkg
// Types and constants of the round-robin time-slice scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

	localparam int MAX_TASKS_DEF = 32;
	localparam int TIME_BITS_DEF = 8;

	localparam int TASK_IDX_W = 5;
	localparam int SVC_W      = 8;
	localparam int USED_W     = 8;
	localparam int CFG_W      = 6;

	localparam logic [CFG_W-1:0] TASK_COUNT_RST = 6'd32;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_PICK,
		ST_READ,
		ST_MODIFY
	} state_t;

	typedef struct packed {
		logic scan;
		logic pick;
	} srch_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/rrts_ram.sv]
// ----------------------------------------------------------------------------
// rrts_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/rrts_search.sv]
// ----------------------------------------------------------------------------
// rrts_search
// Circular first-live search over the live vector, two registered stages.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_search
	import rrts_pkg::*;
#(
	parameter int MAX_TASKS = MAX_TASKS_DEF,
	parameter int IDX_W     = $clog2(MAX_TASKS),
	parameter int CNT_W     = $clog2(MAX_TASKS + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire srch_ctrl_t           ctrl,
	input  wire logic [MAX_TASKS-1:0] live,
	input  wire logic [IDX_W-1:0]     first,
	input  wire logic [CNT_W-1:0]     count,
	output logic                      found,
	output logic      [IDX_W-1:0]     sel
);

	logic [MAX_TASKS-1:0] hi_d, lo_d;
	logic [MAX_TASKS-1:0] hi_s1, lo_s1;
	logic [MAX_TASKS-1:0] hi_one, lo_one, pick;
	logic [IDX_W-1:0]     enc;
	logic                 found_s2;
	logic [IDX_W-1:0]     sel_s2;

	// Stage 1: mask live entries to the active window, split at the start point.
	always_comb begin
		for (int i = 0; i < MAX_TASKS; i++) begin
			lo_d[i] = live[i] && (CNT_W'(i) < count);
			hi_d[i] = lo_d[i] && (IDX_W'(i) >= first);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_s1 <= '0;
			lo_s1 <= '0;
		end else if (ctrl.scan) begin
			hi_s1 <= hi_d;
			lo_s1 <= lo_d;
		end
	end

	// Stage 2: isolate the lowest set bit, upper window first, then wrap.
	always_comb begin
		hi_one = hi_s1 & (~hi_s1 + {{(MAX_TASKS-1){1'b0}}, 1'b1});
		lo_one = lo_s1 & (~lo_s1 + {{(MAX_TASKS-1){1'b0}}, 1'b1});
		pick   = (|hi_s1) ? hi_one : lo_one;
		enc    = '0;
		for (int i = 0; i < MAX_TASKS; i++) begin
			enc = enc | (pick[i] ? IDX_W'(i) : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_s2 <= 1'b0;
			sel_s2   <= '0;
		end else if (ctrl.pick) begin
			found_s2 <= |lo_s1;
			sel_s2   <= enc;
		end
	end

	assign found = found_s2;
	assign sel   = sel_s2;

endmodule

`default_nettype wire

[hw/rtl/round_robin_time_slice_scheduler.sv]
// ----------------------------------------------------------------------------
// round_robin_time_slice_scheduler
// Round-robin time-slice scheduler: task table in RAM, circular live search.
// ----------------------------------------------------------------------------
// Load word: busy while the table entry is written, no result.
// Tick word: busy through scan, pick, RAM read and write back; done is registered
//   from the write-back state and is high for one cycle.
// Tick with nothing live: write back skipped, done registered from the read state.
// A new word is taken only once busy has fallen again.
// Reset: task_count returns to 32, pointer to 0, every task dead; no sweep.
`default_nettype none

module round_robin_time_slice_scheduler
	import rrts_pkg::*;
#(
	parameter int MAX_TASKS = MAX_TASKS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// command channel
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  func,
	input  wire logic [TASK_IDX_W-1:0] task_index,
	input  wire logic [SVC_W-1:0]      service_time,
	// configuration channel (task_count)
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_W-1:0]      cfg_data,
	// result
	output logic                       done,
	output logic      [TASK_IDX_W-1:0] served_task,
	output logic      [USED_W-1:0]     used_time,
	output logic                       finished,
	output logic                       idle
);

	localparam int IDX_W  = $clog2(MAX_TASKS);
	localparam int CNT_W  = $clog2(MAX_TASKS + 1);
	localparam int WORD_W = 2 * TIME_BITS;

	state_t state_q, state_d;

	// captured command word
	logic [TASK_IDX_W-1:0] idx_q;
	logic [SVC_W-1:0]      svc_q;

	logic [CFG_W-1:0]     cfg_q;
	logic [IDX_W-1:0]     ptr_q;
	logic [MAX_TASKS-1:0] live_q;

	logic [TASK_IDX_W-1:0] served_q;
	logic [USED_W-1:0]     used_q;
	logic                  finished_q;
	logic                  idle_q;
	logic                  done_q;

	// effective window and start point
	logic [31:0]      cfg_ext, cnt_ext;
	logic [CNT_W-1:0] count;
	logic [IDX_W-1:0] first;

	// load decode
	logic [31:0]          idx_ext, svc_ext;
	logic                 load_ok;
	logic [IDX_W-1:0]     load_addr;
	logic [TIME_BITS-1:0] load_rem;

	// search
	srch_ctrl_t       srch_ctrl;
	logic             found;
	logic [IDX_W-1:0] sel;

	// RAM ports
	logic              ram_we, ram_re;
	logic [IDX_W-1:0]  ram_waddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;

	// modify path
	logic [TIME_BITS-1:0] rem_old, cons_old, rem_new, cons_new;
	logic [31:0]          sel_ext, nxt_ext, cons_ext;
	logic [IDX_W-1:0]     ptr_nxt;

	// Clamp task_count into 1..MAX_TASKS.
	always_comb begin
		cfg_ext = 32'(cfg_q);
		if (cfg_q == '0) begin
			cnt_ext = 32'd1;
		end else if (cfg_ext > 32'(MAX_TASKS)) begin
			cnt_ext = 32'(MAX_TASKS);
		end else begin
			cnt_ext = cfg_ext;
		end
		count = cnt_ext[CNT_W-1:0];
		// restart at entry 0 when the window shrank below the pointer
		first = (CNT_W'(ptr_q) < count) ? ptr_q : '0;
	end

	// Decode a load word; indexes past the table are dropped.
	always_comb begin
		idx_ext   = 32'(idx_q);
		svc_ext   = 32'(svc_q);
		load_ok   = idx_ext < 32'(MAX_TASKS);
		load_addr = idx_ext[IDX_W-1:0];
		load_rem  = svc_ext[TIME_BITS-1:0];
	end

	// Serve the picked task: count remaining down, used time up with saturation.
	always_comb begin
		rem_old  = ram_rdata[WORD_W-1:TIME_BITS];
		cons_old = ram_rdata[TIME_BITS-1:0];
		rem_new  = rem_old - {{(TIME_BITS-1){1'b0}}, 1'b1};
		cons_new = (cons_old == '1) ? cons_old : cons_old + {{(TIME_BITS-1){1'b0}}, 1'b1};
		cons_ext = 32'(cons_new);
		sel_ext  = 32'(sel);
		nxt_ext  = sel_ext + 32'd1;
		ptr_nxt  = (nxt_ext < 32'(count)) ? nxt_ext[IDX_W-1:0] : '0;
	end

	rrts_search #(
		.MAX_TASKS(MAX_TASKS),
		.IDX_W    (IDX_W),
		.CNT_W    (CNT_W)
	) u_search (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (srch_ctrl),
		.live  (live_q),
		.first (first),
		.count (count),
		.found (found),
		.sel   (sel)
	);

	// One word per task: {remaining, consumed}. A dead task's word is never
	// read, and a load always rewrites both halves, so no clearing is needed.
	rrts_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_TASKS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(sel),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and per-state strobes.
	always_comb begin
		state_d   = state_q;
		busy      = 1'b1;
		srch_ctrl = '0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = sel;
		ram_wdata = {rem_new, cons_new};
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = (func == FUNC_LOAD) ? ST_LOAD : ST_SCAN;
				end
			end
			ST_LOAD: begin
				ram_we    = load_ok;
				ram_waddr = load_addr;
				ram_wdata = {load_rem, {TIME_BITS{1'b0}}};
				state_d   = ST_IDLE;
			end
			ST_SCAN: begin
				srch_ctrl.scan = 1'b1;
				state_d        = ST_PICK;
			end
			ST_PICK: begin
				srch_ctrl.pick = 1'b1;
				state_d        = ST_READ;
			end
			ST_READ: begin
				// fetch the picked entry; with nothing live, finish right here
				ram_re  = found;
				state_d = found ? ST_MODIFY : ST_IDLE;
			end
			ST_MODIFY: begin
				ram_we  = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Capture the command word on accept.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			idx_q <= task_index;
			svc_q <= service_time;
		end
	end

	// Hold task_count, pointer and live vector.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q  <= TASK_COUNT_RST;
			ptr_q  <= '0;
			live_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cfg_q <= cfg_data;
			end
			if (state_q == ST_LOAD && load_ok) begin
				live_q[load_addr] <= (load_rem != '0);
				ptr_q             <= '0;
			end
			if (state_q == ST_MODIFY) begin
				live_q[sel] <= (rem_new != '0);
				ptr_q       <= ptr_nxt;
			end
		end
	end

	// Result strobe: high for exactly one cycle per tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_MODIFY) || (state_q == ST_READ && !found);
		end
	end

	// Result payload; the idle report drives the other fields to zero.
	always_ff @(posedge clk) begin
		if (state_q == ST_READ && !found) begin
			served_q   <= '0;
			used_q     <= '0;
			finished_q <= 1'b0;
			idle_q     <= 1'b1;
		end else if (state_q == ST_MODIFY) begin
			served_q   <= sel_ext[TASK_IDX_W-1:0];
			used_q     <= cons_ext[USED_W-1:0];
			finished_q <= (rem_new == '0);
			idle_q     <= 1'b0;
		end
	end

	// Config only lands between words.
	assign cfg_ready   = !busy;
	assign done        = done_q;
	assign served_task = served_q;
	assign used_time   = used_q;
	assign finished    = finished_q;
	assign idle        = idle_q;

endmodule

`default_nettype wire

[hw/rtl/rrts_checker.sv]
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level timing checks for the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rrts_checker
	import rrts_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  start,
	input wire logic                  busy,
	input wire logic                  func,
	input wire logic                  cfg_valid,
	input wire logic                  cfg_ready,
	input wire logic                  done,
	input wire logic [TASK_IDX_W-1:0] served_task,
	input wire logic [USED_W-1:0]     used_time,
	input wire logic                  finished,
	input wire logic                  idle
);

	// A tick word reports idle when nothing is live, else the served task.
	`ASSERT_IMPLIES(a_tick_latency, clk, arst_n, start && !busy && func == FUNC_TICK, (##4 (done && idle)) or (##5 (done && !idle)))

	// A load word yields no result and frees the block once the load is written.
	`ASSERT_NEXT(a_load_quiet, clk, arst_n, start && !busy && func == FUNC_LOAD, !done && busy ##1 !busy)

	// The result appears only once the block is ready again.
	`ASSERT_IMPLIES(a_done_ready, clk, arst_n, done, !busy)

	// The task count is only written while no word is in flight.
	`ASSERT_IMPLIES(a_cfg_quiet, clk, arst_n, cfg_valid && cfg_ready, !busy)

	// An idle report carries zero fields.
	`ASSERT_IMPLIES(a_idle_zero, clk, arst_n, done && idle, served_task == 0 && used_time == 0 && !finished)

endmodule

bind round_robin_time_slice_scheduler rrts_checker u_rrts_checker (.*);

`default_nettype wire

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// Round-robin time-slice scheduler testbench
// Drives load and tick words through the start/busy port and sets the task
// count between phases. Every tick is predicted from a local copy of the task
// table and search pointer. Each result strobe is matched against the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
	import rrts_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 500;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 20;

	typedef struct {
		logic [TASK_IDX_W-1:0] task_id;
		logic [USED_W-1:0]     used;
		logic                  fin;
		logic                  none_live;
	} sched_result_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  start        = 1'b0;
	logic                  func         = FUNC_LOAD;
	logic [TASK_IDX_W-1:0] task_index   = '0;
	logic [SVC_W-1:0]      service_time = '0;
	logic                  cfg_valid    = 1'b0;
	logic [CFG_W-1:0]      cfg_data     = '0;
	logic                  busy;
	logic                  cfg_ready;
	logic                  done;
	logic [TASK_IDX_W-1:0] served_task;
	logic [USED_W-1:0]     used_time;
	logic                  finished;
	logic                  idle;

	// Shadow of the scheduler state
	logic [SVC_W-1:0]      remaining_units [MAX_TASKS_DEF];
	logic [USED_W-1:0]     consumed_units  [MAX_TASKS_DEF];
	logic [TASK_IDX_W-1:0] search_ptr;
	logic [CFG_W-1:0]      task_count_reg;

	sched_result_t grants_due[$];
	int            fail_count  = 0;
	int            quiet_count = 0;
	bit            no_gaps     = 1'b0;

	round_robin_time_slice_scheduler i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.task_index   (task_index),
		.service_time (service_time),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.done         (done),
		.served_task  (served_task),
		.used_time    (used_time),
		.finished     (finished),
		.idle         (idle)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Apply one accepted word to the shadow table; queue the tick outcome.
	task automatic schedule_word(input logic f, input logic [TASK_IDX_W-1:0] idx,
			input logic [SVC_W-1:0] svc);
		int            span;
		int            first;
		int            slot;
		sched_result_t grant;
		grant = '{task_id: '0, used: '0, fin: 1'b0, none_live: 1'b1};
		if (f == FUNC_LOAD) begin
			// a load rewinds the pointer and clears the used counter
			remaining_units[idx] = svc;
			consumed_units[idx]  = '0;
			search_ptr           = '0;
			return;
		end
		// a count of zero acts as one, anything past the table as the table size
		span = (task_count_reg == 0) ? 1 : int'(task_count_reg);
		if (span > MAX_TASKS_DEF)
			span = MAX_TASKS_DEF;
		// pointer left beyond a lowered count: restart at entry zero
		first = (int'(search_ptr) < span) ? int'(search_ptr) : 0;
		for (int k = 0; k < span; k++) begin
			slot = (first + k) % span;
			if (remaining_units[slot] != 0) begin
				remaining_units[slot] = remaining_units[slot] - 1'b1;
				// saturate the used counter at its maximum
				if (consumed_units[slot] != '1)
					consumed_units[slot] = consumed_units[slot] + 1'b1;
				grant.task_id   = slot[TASK_IDX_W-1:0];
				grant.used      = consumed_units[slot];
				grant.fin       = (remaining_units[slot] == 0);
				grant.none_live = 1'b0;
				search_ptr      = (slot + 1 < span) ? TASK_IDX_W'(slot + 1) : '0;
				break;
			end
		end
		grants_due.push_back(grant);
	endtask

	// ------------------------------------------------------------------------
	// Result checking: done is a one-cycle strobe, so sample it every edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		sched_result_t want;
		if (arst_n && done) begin
			if (grants_due.size() == 0) begin
				$error("result with no tick pending: served_task %0d used_time %0d",
					served_task, used_time);
				fail_count++;
			end else begin
				want = grants_due.pop_front();
				if (served_task !== want.task_id) begin
					$error("served_task: expected %0d, actual %0d", want.task_id, served_task);
					fail_count++;
				end
				if (used_time !== want.used) begin
					$error("used_time: expected %0d, actual %0d", want.used, used_time);
					fail_count++;
				end
				if (finished !== want.fin) begin
					$error("finished: expected %0b, actual %0b", want.fin, finished);
					fail_count++;
				end
				if (idle !== want.none_live) begin
					$error("idle: expected %0b, actual %0b", want.none_live, idle);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: count edges with no word, no register write and no result.
	always @(posedge clk) begin
		if ((start && !busy) || (cfg_valid && cfg_ready) || done)
			quiet_count <= 0;
		else
			quiet_count <= quiet_count + 1;
		if (quiet_count >= WATCHDOG_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Drivers (all called at a rising edge)
	// ------------------------------------------------------------------------

	// Send one word. Start stays high across back-to-back words; lower it only
	// when a gap is drawn, so it never toggles twice in one step.
	task automatic send_word(input logic f, input logic [TASK_IDX_W-1:0] idx,
			input logic [SVC_W-1:0] svc);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		func         <= f;
		task_index   <= idx;
		service_time <= svc;
		do @(posedge clk); while (busy);
		schedule_word(f, idx, svc);
	endtask

	task automatic send_load(input int idx, input int svc);
		send_word(FUNC_LOAD, TASK_IDX_W'(idx), SVC_W'(svc));
	endtask

	// Tick words carry random junk in the ignored fields.
	task automatic send_tick();
		send_word(FUNC_TICK, TASK_IDX_W'($urandom_range(0, 31)),
			SVC_W'($urandom_range(0, 255)));
	endtask

	// Drop start, wait until every predicted result is back, then let a load
	// still in flight finish before anything touches the register.
	task automatic settle();
		start <= 1'b0;
		while (grants_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_task_count(input int value);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= CFG_W'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid      <= 1'b0;
		task_count_reg  = CFG_W'(value);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Empty table after reset: every tick reports idle.
	task automatic test_reset_idle();
		send_tick();
		send_tick();
	endtask

	// Field extremes: top and bottom entries, full and zero service time,
	// a task finishing, and a zero-time load killing a live task.
	task automatic test_field_extremes();
		write_task_count(32);
		send_load(31, 255);
		send_load(0, 1);
		send_tick();
		send_tick();
		send_tick();
		send_load(31, 0);
		send_tick();
	endtask

	// Count of zero acts as one; counts above the table act as the table size.
	// Entries past the count keep their time but are never served.
	task automatic test_count_limits();
		write_task_count(0);
		send_load(0, 2);
		send_load(1, 3);
		send_tick();
		send_tick();
		send_tick();
		write_task_count(63);
		send_tick();
		write_task_count(33);
		send_tick();
	endtask

	// Advance the pointer high, then lower the count below it: the search
	// must restart at entry zero.
	task automatic test_pointer_past_count();
		write_task_count(32);
		send_load(20, 3);
		send_load(2, 3);
		send_tick();
		send_tick();
		write_task_count(8);
		send_tick();
		send_tick();
		write_task_count(32);
		send_tick();
	endtask

	// Random traffic in phases over several counts: loads mostly inside the
	// count with short service times, so tasks keep finishing and reloading.
	task automatic test_random_traffic();
		int cnt;
		int span;
		int pick;
		int svc;
		int idx;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0:       cnt = 1;
				1:       cnt = 32;
				2:       cnt = 0;
				3:       cnt = 63;
				default: cnt = $urandom_range(0, 63);
			endcase
			write_task_count(cnt);
			span    = (cnt == 0) ? 1 : ((cnt > MAX_TASKS_DEF) ? MAX_TASKS_DEF : cnt);
			no_gaps = (phase % 3 == 2);
			repeat (66) begin
				if ($urandom_range(0, 99) < 35) begin
					idx  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
						: $urandom_range(0, span - 1);
					pick = $urandom_range(0, 99);
					if (pick < 10)
						svc = 0;
					else if (pick < 18)
						svc = 255;
					else if (pick < 35)
						svc = $urandom_range(0, 255);
					else
						svc = $urandom_range(1, 6);
					send_load(idx, svc);
				end else begin
					send_tick();
				end
				// hold the sender until the pipeline drains now and then
				if ($urandom_range(0, 39) == 0)
					settle();
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		for (int i = 0; i < MAX_TASKS_DEF; i++) begin
			remaining_units[i] = '0;
			consumed_units[i]  = '0;
		end
		search_ptr     = '0;
		task_count_reg = TASK_COUNT_RST;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_idle();
		test_field_extremes();
		test_count_limits();
		test_pointer_past_count();
		test_random_traffic();

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

`default_nettype wire

[round_robin_time_slice_scheduler.f]
+incdir+hw/rtl
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_ram.sv
hw/rtl/rrts_search.sv
hw/rtl/round_robin_time_slice_scheduler.sv
hw/rtl/rrts_checker.sv
dv/testbench.sv
